// ===== rtl/core/lcit_pkg.sv =====
// Shared constants for the line/circle intersection test.
`timescale 1ns / 1ps
`default_nettype none

package lcit_pkg;

    // Limb width of the multiplier partial products
    localparam int LIMB_W = 32;

    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_RANGE = 2'd2;

    // Configuration reset values
    localparam logic signed [31:0] DIR_X_RST      = 32'sh0001_0000;
    localparam logic signed [31:0] DIR_Y_RST      = 32'sh0000_0000;
    localparam logic [30:0]        HALF_RANGE_RST = 31'h0001_0000;

endpackage

`default_nettype wire

// ===== rtl/core/lcit_mul.sv =====
// Three-stage unsigned limb multiplier: partial products, row sums, total.
`timescale 1ns / 1ps
`default_nettype none

module lcit_mul
    import lcit_pkg::*;
#(
    parameter int A_LIMBS = 2,
    parameter int B_LIMBS = 2
)
(
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [A_LIMBS*LIMB_W-1:0]            a,
    input  wire logic [B_LIMBS*LIMB_W-1:0]            b,
    output logic      [(A_LIMBS+B_LIMBS)*LIMB_W-1:0]  prod
);

    localparam int RW = (B_LIMBS + 1) * LIMB_W;
    localparam int PW = (A_LIMBS + B_LIMBS) * LIMB_W;

    logic [2*LIMB_W-1:0] pp_reg [A_LIMBS][B_LIMBS];
    logic [RW-1:0]       row_reg  [A_LIMBS];
    logic [RW-1:0]       row_next [A_LIMBS];
    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       prod_next;

    always_comb
    begin
        for (int i = 0; i < A_LIMBS; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < B_LIMBS; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * LIMB_W));
            end
        end
    end

    always_comb
    begin
        prod_next = '0;
        for (int i = 0; i < A_LIMBS; i++)
        begin
            prod_next = prod_next + (PW'(row_reg[i]) << (i * LIMB_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < A_LIMBS; i++)
            begin
                for (int j = 0; j < B_LIMBS; j++)
                begin
                    pp_reg[i][j] <= (2*LIMB_W)'(a[i*LIMB_W +: LIMB_W])
                                  * (2*LIMB_W)'(b[j*LIMB_W +: LIMB_W]);
                end
                row_reg[i] <= row_next[i];
            end
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/line_circle_intersect_test_top.sv =====
// Top level of the pipelined line/circle intersection test.
`timescale 1ns / 1ps
`default_nettype none

// Pipelined test of a bounded line against a circle. One transaction is taken
// per clock and each gives one hit result; the pipeline runs through the
// arithmetic chain of small products, two three-stage limb multiplier
// levels (p^2, a*c, a*T, then the two root-bound squares) and the final
// compare. The whole pipeline holds while a result waits on out_ready, so
// in_ready follows out_ready once the output register is full. The test is
// exact: both roots are checked against +-half_range*line_scale by comparing
// squares on wide integers. Configuration writes are always taken and should
// only be made while the pipeline is empty.

module line_circle_intersect_test_top
    import lcit_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [31:0]    line_x,
    input  wire logic signed [31:0]    line_y,
    input  wire logic [30:0]           line_scale,
    input  wire logic signed [31:0]    circle_x,
    input  wire logic signed [31:0]    circle_y,
    input  wire logic [30:0]           radius,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit
);

    localparam int FB   = FRAC_BITS;
    localparam int NV   = 12;
    localparam int MW   = 129;                        // |p^2|, |a*c| bits
    localparam int DW   = MW + 2;                     // discriminant, signed
    localparam int AMW  = 126;                        // a*T bits
    localparam int PSW  = 66 + 2*FB;                  // p scaled, signed
    localparam int UW   = ((AMW > PSW) ? AMW : PSW) + 2;
    localparam int UL   = (UW - 1 + LIMB_W - 1) / LIMB_W;
    localparam int EW   = DW - 1 + 4*FB;
    localparam int SQW  = 2 * UL * LIMB_W;
    localparam int CMPW = (EW > SQW) ? EW : SQW;

    // configuration
    logic signed [31:0] dir_x_reg;
    logic signed [31:0] dir_y_reg;
    logic [30:0]        half_range_reg;

    // control
    logic          en;
    logic [NV-1:0] vld_reg;
    logic          out_valid_reg;

    // stage 1
    logic signed [32:0] s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic signed [31:0] s1_vx_reg, s1_vy_reg;
    logic [30:0]        s1_r_reg;
    logic [61:0]        s1_t_reg, s1_t_next;

    // stage 2
    logic signed [63:0] s2_vxx_reg, s2_vyy_reg;
    logic signed [64:0] s2_vxdx_reg, s2_vydy_reg;
    logic signed [65:0] s2_dxx_reg, s2_dyy_reg;
    logic [61:0]        s2_rr_reg;
    logic [61:0]        s2_t_reg;

    // stage 3
    logic [63:0]        s3_a_reg;
    logic signed [65:0] s3_p_reg;
    logic signed [66:0] s3_c_reg;
    logic [61:0]        s3_t_reg;

    // stage 4
    logic [65:0]             p_abs;
    logic [66:0]             c_abs;
    logic [3*LIMB_W-1:0]     s4_pmag_reg, s4_cmag_reg;
    logic [2*LIMB_W-1:0]     s4_a_reg, s4_t_reg;
    logic signed [65:0]      s4_p_reg;
    logic                    s4_cneg_reg, s4_azero_reg;

    // first multiplier level
    logic [6*LIMB_W-1:0] pp_prod;
    logic [5*LIMB_W-1:0] ac_prod;
    logic [4*LIMB_W-1:0] at_prod;
    logic signed [65:0]  dl_p_reg     [3];
    logic                dl_cneg_reg  [3];
    logic                dl_azero_reg [3];

    // stage 8
    logic signed [DW-1:0]  s8_dd_reg, s8_dd_next;
    logic signed [PSW-1:0] p_shift;
    logic signed [UW-1:0]  p_ext, a_ext;
    logic signed [UW-1:0]  s8_u_reg, s8_w_reg;
    logic                  s8_ok_reg;

    // stage 9
    logic signed [UW-1:0]   u_abs, w_abs;
    logic [UL*LIMB_W-1:0]   s9_umag_reg, s9_wmag_reg;
    logic                   s9_ule0_reg, s9_wge0_reg, s9_dok_reg;
    logic [DW-2:0]          s9_e_reg;

    // second multiplier level
    logic [SQW-1:0] uu_prod, ww_prod;
    logic [DW-2:0]  dl2_e_reg    [3];
    logic           dl2_ule0_reg [3];
    logic           dl2_wge0_reg [3];
    logic           dl2_dok_reg  [3];

    // final compare
    logic [CMPW-1:0] e_ext, uu_ext, ww_ext;
    logic            ge_u, le_u, ge_w, le_w, hit1, hit2;
    logic            hit_reg, hit_next;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg      <= DIR_X_RST;
            dir_y_reg      <= DIR_Y_RST;
            half_range_reg <= HALF_RANGE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIR_X:      dir_x_reg      <= $signed(cfg_data);
                REG_DIR_Y:      dir_y_reg      <= $signed(cfg_data);
                REG_HALF_RANGE: half_range_reg <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // stage 1: offsets and bound
    assign s1_dx_next = 33'(line_x) - 33'(circle_x);
    assign s1_dy_next = 33'(line_y) - 33'(circle_y);
    assign s1_t_next  = 62'(half_range_reg) * 62'(line_scale);

    // stage 4 magnitudes
    assign p_abs = s3_p_reg[65] ? $unsigned(-s3_p_reg) : $unsigned(s3_p_reg);
    assign c_abs = s3_c_reg[66] ? $unsigned(-s3_c_reg) : $unsigned(s3_c_reg);

    // stage 8: discriminant and the two root-bound terms
    assign s8_dd_next = $signed({2'b00, pp_prod[MW-1:0]})
                      + (dl_cneg_reg[2] ? $signed({2'b00, ac_prod[MW-1:0]})
                                        : -$signed({2'b00, ac_prod[MW-1:0]}));
    assign p_shift = $signed({dl_p_reg[2], {(2*FB){1'b0}}});
    assign p_ext   = UW'(p_shift);
    assign a_ext   = UW'($signed({1'b0, at_prod[AMW-1:0]}));

    // stage 9 magnitudes
    assign u_abs = s8_u_reg[UW-1] ? -s8_u_reg : s8_u_reg;
    assign w_abs = s8_w_reg[UW-1] ? -s8_w_reg : s8_w_reg;

    // final compare of D*S^2 against both squared bounds
    assign e_ext  = CMPW'({dl2_e_reg[2], {(4*FB){1'b0}}});
    assign uu_ext = CMPW'(uu_prod);
    assign ww_ext = CMPW'(ww_prod);
    assign ge_u   = e_ext >= uu_ext;
    assign le_u   = e_ext <= uu_ext;
    assign ge_w   = e_ext >= ww_ext;
    assign le_w   = e_ext <= ww_ext;
    // upper root within bound, lower root within bound
    assign hit1     = (dl2_ule0_reg[2] || ge_u) && dl2_wge0_reg[2] && le_w;
    assign hit2     = dl2_ule0_reg[2] && le_u && (dl2_wge0_reg[2] || ge_w);
    assign hit_next = dl2_dok_reg[2] && (hit1 || hit2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg <= s1_dx_next;
            s1_dy_reg <= s1_dy_next;
            s1_vx_reg <= dir_x_reg;
            s1_vy_reg <= dir_y_reg;
            s1_r_reg  <= radius;
            s1_t_reg  <= s1_t_next;

            s2_vxx_reg  <= 64'(s1_vx_reg) * 64'(s1_vx_reg);
            s2_vyy_reg  <= 64'(s1_vy_reg) * 64'(s1_vy_reg);
            s2_vxdx_reg <= 65'(s1_vx_reg) * 65'(s1_dx_reg);
            s2_vydy_reg <= 65'(s1_vy_reg) * 65'(s1_dy_reg);
            s2_dxx_reg  <= 66'(s1_dx_reg) * 66'(s1_dx_reg);
            s2_dyy_reg  <= 66'(s1_dy_reg) * 66'(s1_dy_reg);
            s2_rr_reg   <= 62'(s1_r_reg) * 62'(s1_r_reg);
            s2_t_reg    <= s1_t_reg;

            s3_a_reg <= 64'($unsigned(s2_vxx_reg)) + 64'($unsigned(s2_vyy_reg));
            s3_p_reg <= 66'(s2_vxdx_reg) + 66'(s2_vydy_reg);
            s3_c_reg <= 67'(s2_dxx_reg) + 67'(s2_dyy_reg)
                      - 67'($signed({1'b0, s2_rr_reg}));
            s3_t_reg <= s2_t_reg;

            s4_pmag_reg  <= (3*LIMB_W)'(p_abs);
            s4_cmag_reg  <= (3*LIMB_W)'(c_abs);
            s4_cneg_reg  <= s3_c_reg[66];
            s4_a_reg     <= s3_a_reg;
            s4_t_reg     <= (2*LIMB_W)'(s3_t_reg);
            s4_p_reg     <= s3_p_reg;
            s4_azero_reg <= (s3_a_reg == '0);

            dl_p_reg[0]     <= s4_p_reg;
            dl_cneg_reg[0]  <= s4_cneg_reg;
            dl_azero_reg[0] <= s4_azero_reg;
            for (int k = 1; k < 3; k++)
            begin
                dl_p_reg[k]     <= dl_p_reg[k-1];
                dl_cneg_reg[k]  <= dl_cneg_reg[k-1];
                dl_azero_reg[k] <= dl_azero_reg[k-1];
            end

            s8_dd_reg <= s8_dd_next;
            s8_u_reg  <= p_ext - a_ext;
            s8_w_reg  <= p_ext + a_ext;
            s8_ok_reg <= !dl_azero_reg[2];

            s9_umag_reg <= (UL*LIMB_W)'($unsigned(u_abs));
            s9_wmag_reg <= (UL*LIMB_W)'($unsigned(w_abs));
            s9_ule0_reg <= s8_u_reg[UW-1] || (s8_u_reg == '0);
            s9_wge0_reg <= !s8_w_reg[UW-1];
            s9_dok_reg  <= s8_ok_reg && !s8_dd_reg[DW-1];
            s9_e_reg    <= s8_dd_reg[DW-2:0];

            dl2_e_reg[0]    <= s9_e_reg;
            dl2_ule0_reg[0] <= s9_ule0_reg;
            dl2_wge0_reg[0] <= s9_wge0_reg;
            dl2_dok_reg[0]  <= s9_dok_reg;
            for (int k = 1; k < 3; k++)
            begin
                dl2_e_reg[k]    <= dl2_e_reg[k-1];
                dl2_ule0_reg[k] <= dl2_ule0_reg[k-1];
                dl2_wge0_reg[k] <= dl2_wge0_reg[k-1];
                dl2_dok_reg[k]  <= dl2_dok_reg[k-1];
            end

            hit_reg <= hit_next;
        end
    end

    lcit_mul #(.A_LIMBS(3), .B_LIMBS(3)) u_mul_pp
    (
        .clk  (clk),
        .en   (en),
        .a    (s4_pmag_reg),
        .b    (s4_pmag_reg),
        .prod (pp_prod)
    );

    lcit_mul #(.A_LIMBS(2), .B_LIMBS(3)) u_mul_ac
    (
        .clk  (clk),
        .en   (en),
        .a    (s4_a_reg),
        .b    (s4_cmag_reg),
        .prod (ac_prod)
    );

    lcit_mul #(.A_LIMBS(2), .B_LIMBS(2)) u_mul_at
    (
        .clk  (clk),
        .en   (en),
        .a    (s4_a_reg),
        .b    (s4_t_reg),
        .prod (at_prod)
    );

    lcit_mul #(.A_LIMBS(UL), .B_LIMBS(UL)) u_mul_uu
    (
        .clk  (clk),
        .en   (en),
        .a    (s9_umag_reg),
        .b    (s9_umag_reg),
        .prod (uu_prod)
    );

    lcit_mul #(.A_LIMBS(UL), .B_LIMBS(UL)) u_mul_ww
    (
        .clk  (clk),
        .en   (en),
        .a    (s9_wmag_reg),
        .b    (s9_wmag_reg),
        .prod (ww_prod)
    );

`ifndef SYNTHESIS
    // zero direction or negative discriminant never reports a hit
    a_no_hit_when_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NV-1] && !dl2_dok_reg[2]) |=> !hit_reg)
        else $error("hit reported for a rejected transaction");

    // a stall holds every stage's valid bit
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // a result appears only from the last pipeline stage
    a_out_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[NV-1]))
        else $error("result raised without a transaction in the last stage");
`endif

endmodule

`default_nettype wire
